@@ rtl/core/integer_alu_mul_div_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the integer ALU unit
// Shared forms for same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef INTEGER_ALU_MUL_DIV_UNIT_MACROS_SVH
`define INTEGER_ALU_MUL_DIV_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define IALU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define IALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ialu_pkg.sv @@
// ---------------------------------------------------------------------------
// Integer ALU package
// Operation codes, status codes, work classes and the queued entry format.
// ---------------------------------------------------------------------------
package ialu_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int OPERAND_WIDTH     = 31;
   localparam int PRODUCT_WIDTH     = 2 * OPERAND_WIDTH;
   localparam int OP_WIDTH          = 3;
   localparam int STATUS_WIDTH      = 2;
   localparam int REQ_TDATA_WIDTH   = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH   = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_COUNT_WIDTH   = $clog2(OPERAND_WIDTH);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_REM = 3'd4
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_DIVZERO = 2'd2
   } status_type;

   // Work class decided by the front end; errors need no arithmetic.
   typedef enum logic [2:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_REM,
      KIND_ERR
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      status_type               status;
      logic [OPERAND_WIDTH-1:0] a;
      logic [OPERAND_WIDTH-1:0] b;
   } entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

@@ rtl/core/ialu_front.sv @@
// ---------------------------------------------------------------------------
// Integer ALU front end
// Accepts request items, decodes the operation and flags errors early.
// ---------------------------------------------------------------------------
module ialu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [ialu_pkg::OP_WIDTH-1:0]      in_op,
   input  logic [ialu_pkg::OPERAND_WIDTH-1:0] in_a,
   input  logic [ialu_pkg::OPERAND_WIDTH-1:0] in_b,
   output logic                                push_valid,
   input  logic                                push_ready,
   output ialu_pkg::entry_type                 push_entry
);
   import ialu_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      b_zero;

   assign b_zero = (in_b == '0);

   // Classify the operation; divide by zero becomes an error item here.
   always_comb begin
      entry_in.a      = in_a;
      entry_in.b      = in_b;
      entry_in.status = ST_OK;
      unique case (in_op)
         OP_ADD: begin
            entry_in.kind = KIND_ADD;
         end
         OP_SUB: begin
            entry_in.kind = KIND_SUB;
         end
         OP_MUL: begin
            entry_in.kind = KIND_MUL;
         end
         OP_DIV: begin
            entry_in.kind   = b_zero ? KIND_ERR : KIND_DIV;
            entry_in.status = b_zero ? ST_DIVZERO : ST_OK;
         end
         OP_REM: begin
            entry_in.kind   = b_zero ? KIND_ERR : KIND_REM;
            entry_in.status = b_zero ? ST_DIVZERO : ST_OK;
         end
         default: begin
            entry_in.kind   = KIND_ERR;
            entry_in.status = ST_INVALID;
         end
      endcase
   end

   assign in_ready   = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the queue takes it.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         entry_ff <= entry_in;
      end
   end

endmodule

@@ rtl/core/ialu_queue.sv @@
// ---------------------------------------------------------------------------
// Integer ALU decoupling queue
// Short FIFO of classified items between front end and execution.
// ---------------------------------------------------------------------------
module ialu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ialu_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ialu_pkg::entry_type pop_entry
);
   import ialu_pkg::*;

   entry_type                    slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/ialu_back.sv @@
// ---------------------------------------------------------------------------
// Integer ALU execution back end
// Combinational add, subtract, multiply into the output register; serial restoring divider.
// ---------------------------------------------------------------------------
`include "integer_alu_mul_div_unit_macros.svh"

module ialu_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  ialu_pkg::entry_type              pop_entry,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [ialu_pkg::DATA_WIDTH-1:0]  out_value,
   output ialu_pkg::status_type             out_status
);
   import ialu_pkg::*;

   back_state_type             state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]      rsp_value_ff, rsp_value_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic                       load;
   logic                       out_free;
   logic                       div_start;

   logic [OPERAND_WIDTH-1:0]   rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0]   quot_ff, quot_in;
   logic [OPERAND_WIDTH-1:0]   divisor_ff;
   logic                       is_rem_ff;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;

   logic [DATA_WIDTH-1:0]      sum;
   logic [DATA_WIDTH-1:0]      diff;
   logic [PRODUCT_WIDTH-1:0]   product;
   logic [OPERAND_WIDTH:0]     shifted;
   logic [OPERAND_WIDTH+1:0]   trial;
   logic                       trial_neg;

   assign out_free = !rsp_valid_ff || out_ready;

   assign sum     = {1'b0, pop_entry.a} + {1'b0, pop_entry.b};
   assign diff    = {1'b0, pop_entry.a} - {1'b0, pop_entry.b};
   assign product = pop_entry.a * pop_entry.b;

   // One quotient bit per cycle: shift in the next dividend bit, try subtract.
   assign shifted   = {rem_ff, quot_ff[OPERAND_WIDTH-1]};
   assign trial     = {1'b0, shifted} - {2'b00, divisor_ff};
   assign trial_neg = trial[OPERAND_WIDTH+1];

   always_comb begin
      rem_in   = trial_neg ? shifted[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
      quot_in  = {quot_ff[OPERAND_WIDTH-2:0], !trial_neg};
      count_in = count_ff - 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      pop_ready     = 1'b0;
      div_start     = 1'b0;
      load          = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               if (pop_entry.kind == KIND_DIV || pop_entry.kind == KIND_REM) begin
                  pop_ready = 1'b1;
                  div_start = 1'b1;
                  state_in  = BK_DIV;
               end else if (out_free) begin
                  pop_ready     = 1'b1;
                  load          = 1'b1;
                  rsp_status_in = pop_entry.status;
                  unique case (pop_entry.kind)
                     KIND_ADD: rsp_value_in = sum;
                     KIND_SUB: rsp_value_in = diff;
                     KIND_MUL: rsp_value_in = product[DATA_WIDTH-1:0];
                     default:  rsp_value_in = '0;
                  endcase
               end
            end
         end
         BK_DIV: begin
            if (count_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_value_in = is_rem_ff ? {1'b0, rem_ff} : {1'b0, quot_ff};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Divider datapath: load operands on start, iterate while dividing.
   always_ff @(posedge clock) begin
      if (div_start) begin
         rem_ff     <= '0;
         quot_ff    <= pop_entry.a;
         divisor_ff <= pop_entry.b;
         is_rem_ff  <= (pop_entry.kind == KIND_REM);
         count_ff   <= DIV_COUNT_WIDTH'(OPERAND_WIDTH - 1);
      end else if (state_ff == BK_DIV) begin
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
         count_ff <= count_in;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_value  = rsp_value_ff;
   assign out_status = rsp_status_ff;

   `IALU_ASSERT_SAME(a_no_pop_while_busy, clock, reset, state_ff != BK_IDLE, !pop_ready, "back end popped an item while dividing")
   `IALU_ASSERT_SAME(a_error_value_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_value_ff == '0, "error result carries a nonzero value")
   `IALU_ASSERT_NEXT(a_div_finishes, clock, reset, state_ff == BK_DIV && count_ff == '0, state_ff == BK_DONE, "divider did not finish after its last step")

endmodule

@@ rtl/core/integer_alu_mul_div_unit.sv @@
// ---------------------------------------------------------------------------
// Integer ALU with multiply and divide
// Add, subtract, multiply, divide and remainder on non-negative operands.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one item per accepted req_tvalid/req_tready beat;
//   req_tuser carries the operation code, req_tdata both operands.
//   Result channel (rsp_*): exactly one item per request, in request order;
//   rsp_tdata carries the 32-bit wrapped result, rsp_tuser the status
//   (ok, invalid operation, divide by zero; the value is zero on error).
//   Add, subtract, multiply and all error items pass from acceptance to
//   rsp_tvalid through the front register, the queue and the output
//   register, and sustain one item per cycle while the receiver takes each
//   result and no division runs. Divide and remainder run through a serial
//   restoring divider that retires one quotient bit per cycle: 31 steps plus
//   operand load and writeback; the back end pops no new item until that
//   writeback, so the divider is the throughput limit for that mix.
//   A two-entry queue separates decode from execution, so the front keeps
//   accepting items while a division runs or a result waits.
//   Reset (synchronous, active high) empties the front register, the queue
//   and the output register and returns the divider to idle.
//   When the receiver stalls, the result holds in the output register, the
//   back end stops, then the queue and front fill and req_tready drops.
// ---------------------------------------------------------------------------
module integer_alu_mul_div_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ialu_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,  // [30:0] operand_a, [61:31] operand_b
   input  logic [ialu_pkg::OP_WIDTH-1:0]          req_tuser,  // [2:0] operation
   // Result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ialu_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,  // [31:0] result_value
   output logic [ialu_pkg::STATUS_WIDTH-1:0]      rsp_tuser   // [1:0] status
);
   import ialu_pkg::*;

   logic                     push_valid, push_ready;
   entry_type                push_entry;
   logic                     pop_valid, pop_ready;
   entry_type                pop_entry;
   logic [DATA_WIDTH-1:0]    out_value;
   status_type               out_status;

   // Decode and register incoming items; padding bits of tdata are dropped.
   ialu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_a       (req_tdata[OPERAND_WIDTH-1:0]),
      .in_b       (req_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Buffer classified items so the divider can stall without blocking input.
   ialu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Execute and hold the result until the receiver takes it.
   ialu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (out_value),
      .out_status (out_status)
   );

   assign rsp_tdata = RSP_TDATA_WIDTH'(out_value);
   assign rsp_tuser = out_status;

endmodule
